// ===== hw/rtl/gtfb_pkg.sv =====
`timescale 1ns / 1ps
// constants, cordic angle table and rounding helpers for the gammatone filterbank
// no dependencies

package gtfb_pkg;

  localparam int NUM_CHANNELS_DEF = 16;
  localparam int NUM_STAGES_DEF   = 4;
  localparam int CORDIC_ITERS     = 24;
  localparam logic signed [33:0] CORDIC_K  = 34'sd652032874;
  localparam logic signed [25:0] OUT_SCALE = 26'sd17179869;

  // arctangent of 2^-i in turns * 2^32
  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // round by 2^24 and saturate to 32 bits
  function automatic logic signed [31:0] rnd_sat32(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd8388608) >>> 24;
    if (t > 64'sd2147483647)
      return 32'sh7fffffff;
    else if (t < -64'sd2147483648)
      return 32'sh80000000;
    else
      return t[31:0];
  endfunction

  // round by 2^33 and saturate to 24 bits
  function automatic logic signed [23:0] rnd_sat24(input logic signed [59:0] v);
    logic signed [59:0] t;
    t = (v + 60'sd4294967296) >>> 33;
    if (t > 60'sd8388607)
      return 24'sh7fffff;
    else if (t < -60'sd8388608)
      return 24'sh800000;
    else
      return t[23:0];
  endfunction

endpackage

// ===== hw/rtl/gtfb_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module gtfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/complex_gammatone_filterbank.sv =====
`timescale 1ns / 1ps
// complex gammatone filterbank: downmix, cascaded complex lowpass stages, upmix
// depends on gtfb_pkg and gtfb_ram
// a sample is processed one channel after another, paced by the one shared multiplier
// and 24 cordic iterations per channel
// a load transaction leaves the block idle; the next transaction is taken once the sample ends
// reset: synchronous; a clearing pass over all NUM_CHANNELS*NUM_STAGES stage entries then zeroes
// the filter state, during which no input transaction is accepted

module complex_gammatone_filterbank
  import gtfb_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int NUM_STAGES   = NUM_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // sample[15:0], channel[19:16], coef_gain[43:20], coef_feedback[67:44],
  // phase_step[91:68], zero fill
  input  logic [95:0] in_tdata,
  // func
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_channel[3:0], out_value[27:4], zero fill
  output logic [31:0] out_tdata,
  output logic        out_tlast
);

  localparam int NTOT = NUM_CHANNELS * NUM_STAGES;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SA_W = (NTOT > 1) ? $clog2(NTOT) : 1;
  localparam int K_W  = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD, S_PH, S_PH2, S_COR, S_CEND, S_DX, S_DY, S_DZ,
    S_S0, S_S1, S_S2, S_S3, S_S4, S_S5, S_S6,
    S_U0, S_U1, S_U2, S_U3, S_U4, S_U5
  } state_t;

  state_t state_r;

  logic [23:0]        count_r;
  logic signed [15:0] smp_r;
  logic [CH_W-1:0]    ch_r;
  logic [SA_W-1:0]    sa_r;
  logic [SA_W-1:0]    clr_r;
  logic [K_W-1:0]     k_r;
  logic [4:0]         i_r;
  logic [1:0]         q_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic signed [25:0] c_r, s_r;
  logic signed [31:0] xr_r, xi_r, pr_r, pi_r, yr_r;
  logic signed [32:0] sum_r;
  logic signed [63:0] acc_r;
  logic signed [33:0] h_r;
  logic signed [59:0] prod_r;
  logic               out_valid_r;
  logic [3:0]         out_channel_r;
  logic signed [23:0] out_value_r;
  logic               out_last_r;

  // input fields
  logic               in_func;
  logic signed [15:0] in_sample;
  logic [3:0]         in_channel;
  logic [23:0]        in_gain, in_feedback, in_step;

  assign in_func     = in_tuser;
  assign in_sample   = in_tdata[15:0];
  assign in_channel  = in_tdata[19:16];
  assign in_gain     = in_tdata[43:20];
  assign in_feedback = in_tdata[67:44];
  assign in_step     = in_tdata[91:68];

  logic in_fire;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // memories
  logic            coef_we, coef_re, prev_we, prev_re, stg_we, stg_re;
  logic [CH_W-1:0] coef_waddr, prev_waddr;
  logic [SA_W-1:0] stg_waddr, stg_raddr;
  logic [71:0]     coef_rd;
  logic [63:0]     prev_wd, prev_rd, stg_wd, stg_rd;

  gtfb_ram #(.WIDTH(72), .DEPTH(NUM_CHANNELS), .AW(CH_W)) u_coef_ram (
    .clk(clk), .we(coef_we), .waddr(coef_waddr),
    .wdata({in_step, in_feedback, in_gain}),
    .re(coef_re), .raddr(ch_r), .rdata(coef_rd)
  );

  gtfb_ram #(.WIDTH(64), .DEPTH(NUM_CHANNELS), .AW(CH_W)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wd),
    .re(prev_re), .raddr(ch_r), .rdata(prev_rd)
  );

  gtfb_ram #(.WIDTH(64), .DEPTH(NTOT), .AW(SA_W)) u_stage_ram (
    .clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(stg_wd),
    .re(stg_re), .raddr(stg_raddr), .rdata(stg_rd)
  );

  logic [23:0]        cf_gain, cf_step;
  logic signed [23:0] cf_fb;
  logic signed [31:0] old_re, old_im, prev_re_w, prev_im_w;

  assign cf_gain   = coef_rd[23:0];
  assign cf_fb     = coef_rd[47:24];
  assign cf_step   = coef_rd[71:48];
  assign old_re    = stg_rd[31:0];
  assign old_im    = stg_rd[63:32];
  assign prev_re_w = prev_rd[31:0];
  assign prev_im_w = prev_rd[63:32];

  // derived values
  logic signed [31:0] xi_w, yi_w;
  logic signed [59:0] neg_prod;
  logic signed [59:0] rnd14;
  logic [23:0]        p2;
  logic signed [33:0] xs, ys, at, nx, ny, rc, rs;

  assign neg_prod = -prod_r;
  assign rnd14    = (neg_prod + 60'sd8192) >>> 14;
  assign xi_w     = rnd14[31:0];
  assign yi_w     = rnd_sat32(acc_r);
  assign p2       = prod_r[23:0] + 24'h200000;
  assign xs       = cx_r >>> i_r;
  assign ys       = cy_r >>> i_r;
  assign at       = atan_turn(i_r);

  always_comb begin
    case (q_r)
      2'd0: begin
        nx = cx_r;
        ny = cy_r;
      end
      2'd1: begin
        nx = -cy_r;
        ny = cx_r;
      end
      2'd2: begin
        nx = -cx_r;
        ny = -cy_r;
      end
      default: begin
        nx = cy_r;
        ny = -cx_r;
      end
    endcase
    rc = (nx + 34'sd64) >>> 7;
    rs = (ny + 34'sd64) >>> 7;
  end

  // shared multiplier operand select
  logic signed [33:0] mul_a;
  logic signed [25:0] mul_b;

  always_comb begin
    unique case (state_r)
      S_PH: begin
        mul_a = $signed({10'b0, cf_step});
        mul_b = $signed({2'b0, count_r});
      end
      S_DX: begin
        mul_a = 34'(smp_r);
        mul_b = c_r;
      end
      S_DY: begin
        mul_a = 34'(smp_r);
        mul_b = s_r;
      end
      S_S1, S_S3: begin
        mul_a = 34'(sum_r);
        mul_b = $signed({2'b0, cf_gain});
      end
      S_S2: begin
        mul_a = 34'(old_re);
        mul_b = 26'(cf_fb);
      end
      S_S4: begin
        mul_a = 34'(old_im);
        mul_b = 26'(cf_fb);
      end
      S_U0: begin
        mul_a = 34'(xr_r);
        mul_b = c_r;
      end
      S_U1: begin
        mul_a = 34'(xi_r);
        mul_b = s_r;
      end
      S_U4, S_U5: begin
        mul_a = h_r;
        mul_b = OUT_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // memory control
  always_comb begin
    coef_we    = in_fire && in_func && (32'(in_channel) < 32'(NUM_CHANNELS));
    coef_waddr = CH_W'(in_channel);
    coef_re    = (state_r == S_RD);
    prev_re    = (state_r == S_RD);
    stg_re     = (state_r == S_DZ) || (state_r == S_S6);
    stg_raddr  = (state_r == S_S6) ? SA_W'(sa_r + 1'b1) : sa_r;
    if (state_r == S_CLR) begin
      prev_we    = (32'(clr_r) < 32'(NUM_CHANNELS));
      prev_waddr = CH_W'(clr_r);
      prev_wd    = '0;
      stg_we     = 1'b1;
      stg_waddr  = clr_r;
      stg_wd     = '0;
    end else begin
      prev_we    = (state_r == S_DZ);
      prev_waddr = ch_r;
      prev_wd    = {xi_w, xr_r};
      stg_we     = (state_r == S_S6);
      stg_waddr  = sa_r;
      stg_wd     = {yi_w, yr_r};
    end
  end

  logic signed [59:0] rnd14p;
  logic signed [63:0] rnd23;
  assign rnd14p = (prod_r + 60'sd8192) >>> 14;
  assign rnd23  = (acc_r + 64'sd4194304) >>> 23;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_U5 a departing result is replaced in the same cycle
      if (out_valid_r && out_tready && state_r != S_U5) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= SA_W'(clr_r + 1'b1);
          if (clr_r == SA_W'(NTOT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire && !in_func) begin
            count_r <= count_r + 24'd1;
            smp_r   <= in_sample;
            ch_r    <= '0;
            sa_r    <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_PH;
        S_PH: state_r <= S_PH2;
        S_PH2: begin
          q_r     <= p2[23:22];
          cz_r    <= (34'($signed({12'b0, p2[21:0]})) - 34'sd2097152) <<< 8;
          cx_r    <= CORDIC_K;
          cy_r    <= '0;
          i_r     <= '0;
          state_r <= S_COR;
        end
        S_COR: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + at;
          end
          i_r <= i_r + 5'd1;
          if (i_r == 5'(CORDIC_ITERS - 1)) begin
            state_r <= S_CEND;
          end
        end
        S_CEND: begin
          c_r     <= rc[25:0];
          s_r     <= rs[25:0];
          state_r <= S_DX;
        end
        S_DX: state_r <= S_DY;
        S_DY: begin
          xr_r    <= rnd14p[31:0];
          state_r <= S_DZ;
        end
        S_DZ: begin
          xi_r    <= xi_w;
          pr_r    <= prev_re_w;
          pi_r    <= prev_im_w;
          k_r     <= '0;
          state_r <= S_S0;
        end
        S_S0: begin
          sum_r   <= 33'(xr_r) + 33'(pr_r);
          state_r <= S_S1;
        end
        S_S1: begin
          sum_r   <= 33'(xi_r) + 33'(pi_r);
          state_r <= S_S2;
        end
        S_S2: begin
          acc_r   <= 64'(prod_r);
          state_r <= S_S3;
        end
        S_S3: begin
          acc_r   <= acc_r + (64'(prod_r) <<< 1);
          state_r <= S_S4;
        end
        S_S4: begin
          yr_r    <= rnd_sat32(acc_r);
          acc_r   <= 64'(prod_r);
          state_r <= S_S5;
        end
        S_S5: begin
          acc_r   <= acc_r + (64'(prod_r) <<< 1);
          state_r <= S_S6;
        end
        S_S6: begin
          pr_r <= old_re;
          pi_r <= old_im;
          xr_r <= yr_r;
          xi_r <= yi_w;
          sa_r <= SA_W'(sa_r + 1'b1);
          k_r  <= K_W'(k_r + 1'b1);
          if (k_r == K_W'(NUM_STAGES - 1)) begin
            state_r <= S_U0;
          end else begin
            state_r <= S_S0;
          end
        end
        S_U0: state_r <= S_U1;
        S_U1: begin
          acc_r   <= 64'(prod_r);
          state_r <= S_U2;
        end
        S_U2: begin
          acc_r   <= acc_r - 64'(prod_r);
          state_r <= S_U3;
        end
        S_U3: begin
          h_r     <= rnd23[33:0];
          state_r <= S_U4;
        end
        S_U4: state_r <= S_U5;
        S_U5: begin
          // hold here while the previous result is still pending
          if (!out_valid_r || out_tready) begin
            out_valid_r   <= 1'b1;
            out_channel_r <= 4'(ch_r);
            out_value_r   <= rnd_sat24(prod_r);
            out_last_r    <= (ch_r == CH_W'(NUM_CHANNELS - 1));
            if (ch_r == CH_W'(NUM_CHANNELS - 1)) begin
              state_r <= S_IDLE;
            end else begin
              ch_r    <= CH_W'(ch_r + 1'b1);
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_value_r, out_channel_r};
  assign out_tlast  = out_last_r;

endmodule
